// File: src/ami_pkg.sv
`default_nettype none
package ami_pkg;

	// element and intermediate widths
	localparam int Q_W        = 32;
	localparam int COF_W      = 64;
	localparam int DET_W      = 98;
	localparam int NUM_W      = 98;
	localparam int DIV_STEPS  = 32;
	localparam int WIDE_W     = NUM_W + DIV_STEPS;
	localparam int DIV_LAT    = DIV_STEPS + 3;
	localparam int DIM        = 3;
	localparam int LIN_N      = DIM * DIM;
	localparam int SUM_W      = 66;
	localparam int RND_BITS   = 16;
	localparam int FIFO_DEPTH = 2;

	typedef logic signed [Q_W-1:0]   q_t;
	typedef logic signed [COF_W-1:0] cof_t;
	typedef logic signed [DET_W-1:0] det_t;

	typedef q_t   lin_t [LIN_N];
	typedef q_t   shift_t [DIM];
	typedef cof_t cof_arr_t [LIN_N];

	localparam q_t Q_MAX = 32'sh7FFF_FFFF;
	localparam q_t Q_MIN = 32'sh8000_0000;

	typedef struct packed {
		q_t row0_col0;
		q_t row0_col1;
		q_t row0_col2;
		q_t row0_shift;
		q_t row1_col0;
		q_t row1_col1;
		q_t row1_col2;
		q_t row1_shift;
		q_t row2_col0;
		q_t row2_col1;
		q_t row2_col2;
		q_t row2_shift;
	} in_item_t;

	typedef struct packed {
		q_t inv_row0_col0;
		q_t inv_row0_col1;
		q_t inv_row0_col2;
		q_t inv_row0_shift;
		q_t inv_row1_col0;
		q_t inv_row1_col1;
		q_t inv_row1_col2;
		q_t inv_row1_shift;
		q_t inv_row2_col0;
		q_t inv_row2_col1;
		q_t inv_row2_col2;
		q_t inv_row2_shift;
	} out_item_t;

endpackage
`default_nettype wire

// File: src/affine_matrix_inverse_core.sv
// Inverts one 3x4 affine transform (signed Q16.16) per transfer.
// Input channel: item_valid / item_stall / item. A transfer happens on a
// rising edge with item_valid high and item_stall low.
// Output channel: result_valid / result_stall / result, the inverse linear
// part and the new translation, rounded to nearest and saturated.
// Pipeline from input transfer to result_valid:
// 3 cofactor stages, 3 determinant stages, 35 divider stages (among them
// the restoring steps, one quotient bit each; nine dividers side by side),
// 3 translation stages and the output queue register.
// Throughput: one transform per cycle while item_stall is low, set by the fully pipelined dividers.
// Reset clears every valid bit and empties the output queue; data
// registers are not reset.
// When the receiver stalls, results collect in a two-entry output queue;
// once it is full item_stall rises and the whole pipeline holds in place.
`default_nettype none
module affine_matrix_inverse_core (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               item_valid,
	output logic                    item_stall,
	input  wire ami_pkg::in_item_t  item,
	output logic                    result_valid,
	input  wire logic               result_stall,
	output ami_pkg::out_item_t      result
);
	import ami_pkg::*;

	logic      adv, push, pop;
	logic      cv, dv, tv;
	cof_arr_t  cof_c, cof_d;
	lin_t      lin_c, inv;
	shift_t    shf_c, shf_d;
	det_t      det;
	logic      dly_v_q [DIV_LAT];
	shift_t    dly_shf_q [DIV_LAT];
	out_item_t tres;
	out_item_t ent_q [FIFO_DEPTH];
	logic [1:0] cnt_q;
	logic      wp_q, rp_q;

	// hold the pipeline only when the output queue is full
	assign adv        = cnt_q != 2'(FIFO_DEPTH);
	assign item_stall = !adv;

	ami_cofactor u_cof (
		.clk(clk), .arst_n(arst_n), .adv(adv),
		.vld(item_valid), .item(item),
		.vld_o(cv), .cof(cof_c), .lin(lin_c), .shift(shf_c)
	);

	ami_det u_det (
		.clk(clk), .arst_n(arst_n), .adv(adv),
		.vld(cv), .cof(cof_c), .lin(lin_c), .shift(shf_c),
		.vld_o(dv), .cof_o(cof_d), .det(det), .shift_o(shf_d)
	);

	for (genvar e = 0; e < LIN_N; e++) begin : g_div
		ami_divider u_div (
			.clk(clk), .adv(adv), .cof(cof_d[e]), .det(det), .inv(inv[e])
		);
	end

	// delay valid and translation alongside the dividers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < DIV_LAT; k++) begin
				dly_v_q[k] <= 1'b0;
			end
		end else if (adv) begin
			dly_v_q[0] <= dv;
			for (int k = 1; k < DIV_LAT; k++) begin
				dly_v_q[k] <= dly_v_q[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dly_shf_q[0] <= shf_d;
			for (int k = 1; k < DIV_LAT; k++) begin
				dly_shf_q[k] <= dly_shf_q[k-1];
			end
		end
	end

	ami_translate u_tr (
		.clk(clk), .arst_n(arst_n), .adv(adv),
		.vld(dly_v_q[DIV_LAT-1]), .inv(inv), .shift(dly_shf_q[DIV_LAT-1]),
		.vld_o(tv), .res(tres)
	);

	// output queue
	assign push         = adv && tv;
	assign pop          = result_valid && !result_stall;
	assign result_valid = cnt_q != 2'd0;
	assign result       = ent_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
		end else begin
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
			if (push) begin
				wp_q <= !wp_q;
			end
			if (pop) begin
				rp_q <= !rp_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= tres;
		end
	end

	// queue occupancy rises on a push without a pop and never exceeds the depth
	a_cnt_inc: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> cnt_q == $past(cnt_q) + 2'd1)
		else $error("queue count did not follow a push");

	a_cnt_max: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 2'(FIFO_DEPTH))
		else $error("queue overfilled");

	// a held pipeline keeps its last stage in place
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(tv))
		else $error("pipeline moved while held");

endmodule
`default_nettype wire

// File: src/ami_cofactor.sv
`default_nettype none
module ami_cofactor (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              adv,
	input  wire logic              vld,
	input  wire ami_pkg::in_item_t item,
	output logic                   vld_o,
	output ami_pkg::cof_arr_t      cof,
	output ami_pkg::lin_t          lin,
	output ami_pkg::shift_t        shift
);
	import ami_pkg::*;

	// operand indices of each cofactor a*b - c*d, row-major linear index
	localparam int unsigned IA [LIN_N] = '{4, 7, 1, 6, 0, 3, 3, 6, 0};
	localparam int unsigned IB [LIN_N] = '{8, 2, 5, 5, 8, 2, 7, 1, 4};
	localparam int unsigned IC [LIN_N] = '{7, 1, 4, 3, 6, 0, 6, 0, 3};
	localparam int unsigned ID [LIN_N] = '{5, 8, 2, 8, 2, 5, 4, 7, 1};

	logic     v_s1, v_s2, v_s3;
	lin_t     lin_s1, lin_s2, lin_s3;
	shift_t   shf_s1, shf_s2, shf_s3;
	cof_arr_t pa_s2, pb_s2, cof_s3;

	// advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= vld;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// capture the transfer
	always_ff @(posedge clk) begin
		if (adv) begin
			lin_s1 <= '{item.row0_col0, item.row0_col1, item.row0_col2,
			            item.row1_col0, item.row1_col1, item.row1_col2,
			            item.row2_col0, item.row2_col1, item.row2_col2};
			shf_s1 <= '{item.row0_shift, item.row1_shift, item.row2_shift};
			lin_s2 <= lin_s1;
			shf_s2 <= shf_s1;
			lin_s3 <= lin_s2;
			shf_s3 <= shf_s2;
		end
	end

	// form products, then exact differences
	for (genvar e = 0; e < LIN_N; e++) begin : g_cof
		always_ff @(posedge clk) begin
			if (adv) begin
				pa_s2[e]  <= lin_s1[IA[e]] * lin_s1[IB[e]];
				pb_s2[e]  <= lin_s1[IC[e]] * lin_s1[ID[e]];
				cof_s3[e] <= pa_s2[e] - pb_s2[e];
			end
		end
	end

	assign vld_o = v_s3;
	assign cof   = cof_s3;
	assign lin   = lin_s3;
	assign shift = shf_s3;

endmodule
`default_nettype wire

// File: src/ami_det.sv
`default_nettype none
module ami_det (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              adv,
	input  wire logic              vld,
	input  wire ami_pkg::cof_arr_t cof,
	input  wire ami_pkg::lin_t     lin,
	input  wire ami_pkg::shift_t   shift,
	output logic                   vld_o,
	output ami_pkg::cof_arr_t      cof_o,
	output ami_pkg::det_t          det,
	output ami_pkg::shift_t        shift_o
);
	import ami_pkg::*;

	// cofactors of column 0 pair with row 0 of the linear part
	localparam int unsigned CI [DIM] = '{0, 3, 6};

	logic                    v_s1, v_s2, v_s3;
	cof_arr_t                cof_s1, cof_s2, cof_s3;
	shift_t                  shf_s1, shf_s2, shf_s3;
	logic signed [COF_W:0]   pl_s1 [DIM];
	logic signed [COF_W-1:0] ph_s1 [DIM];
	det_t                    prod_s2 [DIM];
	det_t                    det_s3;

	// advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= vld;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// split each 64x32 product into two partial products over the 32-bit cofactor halves, then join
	for (genvar r = 0; r < DIM; r++) begin : g_term
		always_ff @(posedge clk) begin
			if (adv) begin
				pl_s1[r]   <= $signed({1'b0, cof[CI[r]][Q_W-1:0]}) * lin[r];
				ph_s1[r]   <= $signed(cof[CI[r]][COF_W-1:Q_W]) * lin[r];
				prod_s2[r] <= {{(DET_W-COF_W-Q_W){ph_s1[r][COF_W-1]}}, ph_s1[r], {Q_W{1'b0}}}
				            + {{(DET_W-COF_W-1){pl_s1[r][COF_W]}}, pl_s1[r]};
			end
		end
	end

	// sum the expansion along row 0 and carry the side data
	always_ff @(posedge clk) begin
		if (adv) begin
			det_s3 <= prod_s2[0] + prod_s2[1] + prod_s2[2];
			cof_s1 <= cof;
			cof_s2 <= cof_s1;
			cof_s3 <= cof_s2;
			shf_s1 <= shift;
			shf_s2 <= shf_s1;
			shf_s3 <= shf_s2;
		end
	end

	assign vld_o   = v_s3;
	assign cof_o   = cof_s3;
	assign det     = det_s3;
	assign shift_o = shf_s3;

endmodule
`default_nettype wire

// File: src/ami_divider.sv
`default_nettype none
module ami_divider (
	input  wire logic          clk,
	input  wire logic          adv,
	input  wire ami_pkg::cof_t cof,
	input  wire ami_pkg::det_t det,
	output ami_pkg::q_t        inv
);
	import ami_pkg::*;

	typedef struct packed {
		logic neg;
		logic sat;
		logic dz;
		logic cz;
		logic cn;
	} div_flag_t;

	logic [COF_W-1:0]   an;
	det_t               ad_full;
	logic [DET_W-2:0]   ad;
	logic               cn, dn;
	logic [NUM_W-1:0]   n_s1, d_s1;
	div_flag_t          flg_s1;
	logic               ovf;
	logic [NUM_W-1:0]   rem_s [DIV_STEPS];
	logic [NUM_W-1:0]   d_s [DIV_STEPS];
	logic [Q_W-1:0]     quo_s [DIV_STEPS+1];
	div_flag_t          flg_s [DIV_STEPS+1];
	logic [Q_W-1:0]     q;
	div_flag_t          fl;
	q_t                 res_nx, res_s;

	// magnitudes and rounding offset: (2|c|*2^32 + |d|) / (2|d|)
	always_comb begin
		cn      = cof[COF_W-1];
		dn      = det[DET_W-1];
		an      = cn ? COF_W'(-cof) : COF_W'(cof);
		ad_full = dn ? -det : det;
		ad      = ad_full[DET_W-2:0];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			n_s1   <= {1'b0, an, {(Q_W+1){1'b0}}} + {1'b0, ad};
			d_s1   <= {ad, 1'b0};
			flg_s1 <= '{neg: cn ^ dn, sat: 1'b0, dz: (det == '0), cz: (cof == '0), cn: cn};
		end
	end

	// detect a quotient beyond 32 bits
	assign ovf = WIDE_W'(n_s1) >= (WIDE_W'(d_s1) << DIV_STEPS);

	always_ff @(posedge clk) begin
		if (adv) begin
			rem_s[0] <= n_s1;
			d_s[0]   <= d_s1;
			quo_s[0] <= '0;
			flg_s[0] <= '{neg: flg_s1.neg, sat: ovf, dz: flg_s1.dz, cz: flg_s1.cz,
			              cn: flg_s1.cn};
		end
	end

	// one restoring step per stage, quotient bit DIV_STEPS-1 first
	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
		localparam int SH = DIV_STEPS - 1 - k;
		logic [WIDE_W-1:0] dsh, rw, dif;
		logic              fits;

		always_comb begin
			dsh  = WIDE_W'(d_s[k]) << SH;
			rw   = WIDE_W'(rem_s[k]);
			fits = rw >= dsh;
			dif  = rw - dsh;
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				quo_s[k+1] <= fits ? (quo_s[k] | (Q_W'(1) << SH)) : quo_s[k];
				flg_s[k+1] <= flg_s[k];
			end
		end

		if (k < DIV_STEPS - 1) begin : g_keep
			always_ff @(posedge clk) begin
				if (adv) begin
					rem_s[k+1] <= fits ? dif[NUM_W-1:0] : rem_s[k];
					d_s[k+1]   <= d_s[k];
				end
			end
		end
	end

	// apply sign and saturate; a zero determinant gives zero or a full-scale value by the cofactor sign
	always_comb begin
		q  = quo_s[DIV_STEPS];
		fl = flg_s[DIV_STEPS];
		if (fl.dz) begin
			res_nx = fl.cz ? q_t'(0) : (fl.cn ? Q_MIN : Q_MAX);
		end else if (fl.neg) begin
			res_nx = (fl.sat || q > 32'h8000_0000) ? Q_MIN : q_t'(-q);
		end else begin
			res_nx = (fl.sat || q[Q_W-1]) ? Q_MAX : q_t'(q);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s <= res_nx;
		end
	end

	assign inv = res_s;

endmodule
`default_nettype wire

// File: src/ami_translate.sv
`default_nettype none
module ami_translate (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            adv,
	input  wire logic            vld,
	input  wire ami_pkg::lin_t   inv,
	input  wire ami_pkg::shift_t shift,
	output logic                 vld_o,
	output ami_pkg::out_item_t   res
);
	import ami_pkg::*;

	localparam logic [SUM_W-1:0] RND_HALF = SUM_W'(1) << (RND_BITS - 1);

	logic                    v_s1, v_s2, v_s3;
	lin_t                    inv_s1, inv_s2, inv_s3;
	logic signed [2*Q_W-1:0] prod_s1 [LIN_N];
	logic signed [SUM_W-1:0] sum_s2 [DIM];
	q_t                      tr_s3 [DIM];

	// advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= vld;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			inv_s1 <= inv;
			inv_s2 <= inv_s1;
			inv_s3 <= inv_s2;
		end
	end

	for (genvar i = 0; i < DIM; i++) begin : g_row
		logic [SUM_W-1:0] mag, rq;
		logic             sneg;
		q_t               tr_nx;

		// multiply the rounded inverse row with the old translation
		for (genvar k = 0; k < DIM; k++) begin : g_col
			always_ff @(posedge clk) begin
				if (adv) begin
					prod_s1[i*DIM+k] <= inv[i*DIM+k] * shift[k];
				end
			end
		end

		// negate, round to nearest with ties away from zero, saturate
		always_comb begin
			sneg = sum_s2[i][SUM_W-1];
			mag  = sneg ? SUM_W'(-sum_s2[i]) : SUM_W'(sum_s2[i]);
			rq   = (mag + RND_HALF) >> RND_BITS;
			if (!sneg && sum_s2[i] != '0) begin
				tr_nx = (rq > SUM_W'(33'h0_8000_0000)) ? Q_MIN : q_t'(-rq[Q_W-1:0]);
			end else begin
				tr_nx = (rq > SUM_W'(32'h7FFF_FFFF)) ? Q_MAX : q_t'(rq[Q_W-1:0]);
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				sum_s2[i] <= SUM_W'(prod_s1[i*DIM]) + SUM_W'(prod_s1[i*DIM+1])
				           + SUM_W'(prod_s1[i*DIM+2]);
				tr_s3[i]  <= tr_nx;
			end
		end
	end

	assign vld_o = v_s3;

	always_comb begin
		res.inv_row0_col0  = inv_s3[0];
		res.inv_row0_col1  = inv_s3[1];
		res.inv_row0_col2  = inv_s3[2];
		res.inv_row0_shift = tr_s3[0];
		res.inv_row1_col0  = inv_s3[3];
		res.inv_row1_col1  = inv_s3[4];
		res.inv_row1_col2  = inv_s3[5];
		res.inv_row1_shift = tr_s3[1];
		res.inv_row2_col0  = inv_s3[6];
		res.inv_row2_col1  = inv_s3[7];
		res.inv_row2_col2  = inv_s3[8];
		res.inv_row2_shift = tr_s3[2];
	end

endmodule
`default_nettype wire
